[rtl/cce_pkg.sv]
// cce_pkg: constants and character helpers for the escape sequence encoder
// no dependencies; imported by cpp_char_escape_encoder_top
package cce_pkg;

    localparam int unsigned CP_W   = 21;
    localparam int unsigned CHAR_W = 7;
    localparam int unsigned LEN_W  = 4;
    localparam int unsigned POS_W  = 4;

    localparam logic [CHAR_W-1:0] CH_BACKSLASH = 7'h5C;
    localparam logic [CHAR_W-1:0] CH_QUOTE     = 7'h22;
    localparam logic [CHAR_W-1:0] CH_ZERO      = 7'h30;
    localparam logic [CHAR_W-1:0] CH_HEX_ALPHA = 7'h37;
    localparam logic [CHAR_W-1:0] CH_LOWER_U   = 7'h75;
    localparam logic [CHAR_W-1:0] CH_UPPER_U   = 7'h55;
    localparam logic [CHAR_W-1:0] CH_NONE      = 7'h00;

    localparam logic [LEN_W-1:0] LEN_SHORT = 4'd2;
    localparam logic [LEN_W-1:0] LEN_OCTAL = 4'd4;
    localparam logic [LEN_W-1:0] LEN_HEX4  = 4'd6;
    localparam logic [LEN_W-1:0] LEN_HEX8  = 4'd10;

    localparam logic [CP_W-1:0] CP_ASCII_END = 21'h00080;
    localparam logic [CP_W-1:0] CP_BMP_MAX   = 21'h0FFFF;

    // letter of the two-character form, zero when there is none
    function automatic logic [CHAR_W-1:0] short_char(input logic [CP_W-1:0] cp);
        logic [CHAR_W-1:0] ch;
        ch = CH_NONE;
        if (cp[CP_W-1:CHAR_W] == '0) begin
            unique case (cp[CHAR_W-1:0])
                7'h22:   ch = CH_QUOTE;
                7'h5C:   ch = CH_BACKSLASH;
                7'h07:   ch = 7'h61;
                7'h08:   ch = 7'h62;
                7'h0C:   ch = 7'h66;
                7'h0A:   ch = 7'h6E;
                7'h0D:   ch = 7'h72;
                7'h09:   ch = 7'h74;
                7'h0B:   ch = 7'h76;
                default: ch = CH_NONE;
            endcase
        end
        return ch;
    endfunction

    function automatic logic [LEN_W-1:0] run_len(input logic [CP_W-1:0] cp);
        logic [LEN_W-1:0] len;
        if (short_char(cp) != CH_NONE) begin
            len = LEN_SHORT;
        end else if (cp < CP_ASCII_END) begin
            len = LEN_OCTAL;
        end else if (cp <= CP_BMP_MAX) begin
            len = LEN_HEX4;
        end else begin
            len = LEN_HEX8;
        end
        return len;
    endfunction

    function automatic logic [CHAR_W-1:0] hex_char(input logic [3:0] d);
        logic [CHAR_W-1:0] ch;
        if (d < 4'd10) begin
            ch = CH_ZERO + {3'b000, d};
        end else begin
            ch = CH_HEX_ALPHA + {3'b000, d};
        end
        return ch;
    endfunction

    // character at position pos of the sequence for cp
    function automatic logic [CHAR_W-1:0] char_at(input logic [CP_W-1:0] cp,
                                                  input logic [POS_W-1:0] pos);
        logic [CHAR_W-1:0] sc;
        logic [LEN_W-1:0]  len;
        logic [31:0]       cp_wide;
        logic [POS_W-1:0]  nib_sel;
        logic [2:0]        oct_digit;
        logic [3:0]        nib;
        logic [CHAR_W-1:0] ch;
        sc       = short_char(cp);
        len      = run_len(cp);
        cp_wide  = {11'd0, cp};
        nib_sel  = (len == LEN_HEX8) ? (4'd9 - pos) : (4'd5 - pos);
        nib      = cp_wide[{nib_sel[2:0], 2'b00} +: 4];
        oct_digit = 3'd0;
        case (pos)
            4'd1:    oct_digit = {1'b0, cp[7:6]};
            4'd2:    oct_digit = cp[5:3];
            default: oct_digit = cp[2:0];
        endcase
        if (pos == '0) begin
            ch = CH_BACKSLASH;
        end else if (len == LEN_SHORT) begin
            ch = sc;
        end else if (len == LEN_OCTAL) begin
            ch = CH_ZERO + {4'd0, oct_digit};
        end else if (pos == 4'd1) begin
            ch = (len == LEN_HEX8) ? CH_UPPER_U : CH_LOWER_U;
        end else begin
            ch = hex_char(nib);
        end
        return ch;
    endfunction

endpackage

[rtl/cpp_char_escape_encoder_top.sv]
// cpp_char_escape_encoder_top: emits the escape sequence of one code point,
// one character per output transfer; depends on cce_pkg
// the code point is held in held_cp_reg, and each character is then registered in out_char_reg
// throughput: one character per cycle while m_ready is high, so each item takes 2, 4, 6 or 10
// characters (its run length); the next item is taken as the last character is loaded
// reset: synchronous active-low aresetn clears the run and output valid
module cpp_char_escape_encoder_top (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic [cce_pkg::CP_W-1:0]    s_code_point,
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic [cce_pkg::CHAR_W-1:0]  m_out_char,
    output logic [cce_pkg::LEN_W-1:0]   m_run_length,
    output logic                        m_last_of_run
);
    import cce_pkg::*;

    logic [CP_W-1:0]   held_cp_reg, held_cp_next;
    logic [POS_W-1:0]  emit_pos_reg, emit_pos_next;
    logic              run_active_reg, run_active_next;
    logic              m_valid_reg, m_valid_next;
    logic [CHAR_W-1:0] out_char_reg, out_char_next;
    logic [LEN_W-1:0]  run_len_reg, run_len_next;
    logic              last_reg, last_next;

    logic [LEN_W-1:0]  cur_len;
    logic              advance;
    logic              is_last;
    logic              s_xfer;

    assign cur_len = run_len(held_cp_reg);
    assign advance = run_active_reg && (!m_valid_reg || m_ready);
    assign is_last = (emit_pos_reg + 4'd1) == cur_len;
    assign s_ready = !run_active_reg || (advance && is_last);
    assign s_xfer  = s_valid && s_ready;

    always_comb begin
        held_cp_next    = held_cp_reg;
        emit_pos_next   = emit_pos_reg;
        run_active_next = run_active_reg;
        m_valid_next    = m_valid_reg;
        out_char_next   = out_char_reg;
        run_len_next    = run_len_reg;
        last_next       = last_reg;
        if (m_ready) begin
            m_valid_next = 1'b0;
        end
        if (advance) begin
            m_valid_next  = 1'b1;
            out_char_next = char_at(held_cp_reg, emit_pos_reg);
            run_len_next  = cur_len;
            last_next     = is_last;
            emit_pos_next = emit_pos_reg + 4'd1;
            if (is_last) begin
                run_active_next = 1'b0;
            end
        end
        if (s_xfer) begin
            held_cp_next    = s_code_point;
            emit_pos_next   = '0;
            run_active_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            held_cp_reg    <= '0;
            emit_pos_reg   <= '0;
            run_active_reg <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            held_cp_reg    <= held_cp_next;
            emit_pos_reg   <= emit_pos_next;
            run_active_reg <= run_active_next;
            m_valid_reg    <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_char_reg <= out_char_next;
        run_len_reg  <= run_len_next;
        last_reg     <= last_next;
    end

    assign m_valid       = m_valid_reg;
    assign m_out_char    = out_char_reg;
    assign m_run_length  = run_len_reg;
    assign m_last_of_run = last_reg;

    // a new run starts at the backslash
    a_run_start: assert property (@(posedge aclk) disable iff (!aresetn)
        s_xfer |=> run_active_reg && emit_pos_reg == '0)
        else $error("run did not start at position zero");

    // position stays inside the sequence while a run is active
    a_pos_range: assert property (@(posedge aclk) disable iff (!aresetn)
        run_active_reg |-> emit_pos_reg < cur_len)
        else $error("emit position beyond run length");

    // input is not taken while characters of the run remain
    a_no_overrun: assert property (@(posedge aclk) disable iff (!aresetn)
        (run_active_reg && !(advance && is_last)) |-> !s_ready)
        else $error("input ready in the middle of a run");

    // the first character of every run is a backslash
    a_lead_char: assert property (@(posedge aclk) disable iff (!aresetn)
        (advance && emit_pos_reg == '0) |=> m_out_char == CH_BACKSLASH)
        else $error("run did not lead with a backslash");

    // the last character is flagged, valid and carries a legal run length
    a_last_len: assert property (@(posedge aclk) disable iff (!aresetn)
        (advance && is_last) |=> m_last_of_run && m_valid &&
            (m_run_length == LEN_SHORT || m_run_length == LEN_OCTAL ||
             m_run_length == LEN_HEX4 || m_run_length == LEN_HEX8))
        else $error("last character with a bad run length");

endmodule

[verif/tb_cpp_char_escape_encoder_top.sv]
`timescale 1ns / 1ps
// tb_cpp_char_escape_encoder_top: self-checking bench for the escape sequence encoder
// directed table then random code points, random gaps on both channels, one long output hold
// depends on cce_pkg and cpp_char_escape_encoder_top
module tb_cpp_char_escape_encoder_top;

    import cce_pkg::*;

    localparam int DIR_N    = 25;
    localparam int RAND_N   = 195;
    localparam int HOLD_LEN = 300;

    typedef struct packed {
        logic [CHAR_W-1:0] ch;
        logic [LEN_W-1:0]  len;
        logic              last;
    } esc_char_t;

    logic                aclk = 1'b0;
    logic                aresetn;
    logic                s_valid;
    logic                s_ready;
    logic [CP_W-1:0]     s_code_point;
    logic                m_valid;
    logic                m_ready;
    logic [CHAR_W-1:0]   m_out_char;
    logic [LEN_W-1:0]    m_run_length;
    logic                m_last_of_run;

    esc_char_t expected_chars[$];
    int        fail_count = 0;
    bit        no_idle = 1'b0;
    bit        hold_request = 1'b0;

    string HEX_DIGITS = "0123456789ABCDEF";

    logic [CP_W-1:0] short_cps [9] = '{21'h22, 21'h5C, 21'h07, 21'h08, 21'h0C,
                                       21'h0A, 21'h0D, 21'h09, 21'h0B};

    // empty string: expectation comes from the predictor
    logic [CP_W-1:0] dir_cp [DIR_N] = '{
        21'h000000, 21'h000007, 21'h000008, 21'h000009, 21'h00000A,
        21'h00000B, 21'h00000C, 21'h00000D, 21'h000022, 21'h00005C,
        21'h000001, 21'h000020, 21'h000041, 21'h00007F, 21'h000080,
        21'h0000FF, 21'h00D800, 21'h00DFFF, 21'h00FFFF, 21'h010000,
        21'h10FFFF, 21'h110000, 21'h1FFFFF, 21'h0AAAAA, 21'h155555
    };
    string dir_lit [DIR_N] = '{
        "\\000", "\\a", "\\b", "\\t", "\\n",
        "\\v", "\\f", "\\r", "\\\"", "\\\\",
        "", "", "", "\\177", "\\u0080",
        "", "", "", "\\uFFFF", "\\U00010000",
        "\\U0010FFFF", "", "\\U001FFFFF", "", ""
    };

    cpp_char_escape_encoder_top u_top (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_code_point  (s_code_point),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_out_char    (m_out_char),
        .m_run_length  (m_run_length),
        .m_last_of_run (m_last_of_run)
    );

    always #5 aclk = ~aclk;

    function automatic logic [CHAR_W-1:0] hex_ascii(input logic [3:0] d);
        byte b;
        b = HEX_DIGITS[int'(d)];
        return b[CHAR_W-1:0];
    endfunction

    task automatic push_escape_of(input logic [CP_W-1:0] cp);
        logic [CHAR_W-1:0] seq [10];
        logic [CHAR_W-1:0] letter;
        logic [31:0]       cp_wide;
        int                n;
        esc_char_t         e;
        letter = '0;
        cp_wide = {11'd0, cp};
        case (cp)
            21'h22:  letter = 7'h22;
            21'h5C:  letter = 7'h5C;
            21'h07:  letter = 7'h61;
            21'h08:  letter = 7'h62;
            21'h0C:  letter = 7'h66;
            21'h0A:  letter = 7'h6E;
            21'h0D:  letter = 7'h72;
            21'h09:  letter = 7'h74;
            21'h0B:  letter = 7'h76;
            default: letter = '0;
        endcase
        seq[0] = 7'h5C;
        n = 1;
        if (letter != '0) begin
            seq[1] = letter;
            n = 2;
        end else if (cp < 21'h80) begin
            seq[1] = 7'h30 + {4'd0, cp[8:6]};
            seq[2] = 7'h30 + {4'd0, cp[5:3]};
            seq[3] = 7'h30 + {4'd0, cp[2:0]};
            n = 4;
        end else if (cp <= 21'hFFFF) begin
            seq[1] = 7'h75;
            for (int k = 0; k < 4; k++) seq[2 + k] = hex_ascii(cp_wide[4 * (3 - k) +: 4]);
            n = 6;
        end else begin
            seq[1] = 7'h55;
            for (int k = 0; k < 8; k++) seq[2 + k] = hex_ascii(cp_wide[4 * (7 - k) +: 4]);
            n = 10;
        end
        for (int k = 0; k < n; k++) begin
            e.ch   = seq[k];
            e.len  = n[LEN_W-1:0];
            e.last = (k == n - 1);
            expected_chars.push_back(e);
        end
    endtask

    task automatic push_literal(input string lit);
        esc_char_t e;
        byte       b;
        int        n;
        n = lit.len();
        for (int k = 0; k < n; k++) begin
            b      = lit[k];
            e.ch   = b[CHAR_W-1:0];
            e.len  = n[LEN_W-1:0];
            e.last = (k == n - 1);
            expected_chars.push_back(e);
        end
    endtask

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (no_idle)
            return 0;
        else if (r < 55)
            return 0;
        else if (r < 90)
            return $urandom_range(1, 3);
        else
            return $urandom_range(8, 30);
    endfunction

    function automatic logic [CP_W-1:0] pick_code_point();
        logic [31:0] r;
        case ($urandom_range(0, 9))
            0:       r = {11'd0, short_cps[$urandom_range(0, 8)]};
            1, 2:    r = $urandom_range(0, 127);
            3:       r = $urandom_range(128, 255);
            4:       r = $urandom_range(256, 32'hFFFF);
            5:       r = $urandom_range(32'hD800, 32'hDFFF);
            6, 7:    r = $urandom_range(32'h10000, 32'h10FFFF);
            8:       r = $urandom_range(32'h110000, 32'h1FFFFF);
            default: r = $urandom();
        endcase
        return r[CP_W-1:0];
    endfunction

    // called just after a posedge; returns just after the accepting posedge
    task automatic send_item(input logic [CP_W-1:0] cp, input string lit, input int gap);
        @(negedge aclk);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid      <= 1'b1;
        s_code_point <= cp;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        if (lit.len() == 0)
            push_escape_of(cp);
        else
            push_literal(lit);
    endtask

    task automatic check_char();
        esc_char_t e;
        if (expected_chars.size() == 0) begin
            $error("unexpected output transfer: out_char %0h", m_out_char);
            fail_count++;
        end else begin
            e = expected_chars.pop_front();
            if (m_out_char !== e.ch) begin
                $error("out_char expected %0h actual %0h", e.ch, m_out_char);
                fail_count++;
            end
            if (m_run_length !== e.len) begin
                $error("run_length expected %0d actual %0d", e.len, m_run_length);
                fail_count++;
            end
            if (m_last_of_run !== e.last) begin
                $error("last_of_run expected %0b actual %0b", e.last, m_last_of_run);
                fail_count++;
            end
        end
    endtask

    always @(posedge aclk) begin
        if (aresetn === 1'b1 && m_valid === 1'b1 && m_ready === 1'b1) check_char();
    end

    // output side backpressure
    initial begin : sink
        int stall_left;
        int r;
        stall_left = 0;
        m_ready = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_request) begin
                hold_request = 1'b0;
                stall_left = HOLD_LEN;
            end else if (stall_left == 0 && !no_idle) begin
                r = $urandom_range(0, 99);
                if (r < 20)
                    stall_left = $urandom_range(1, 3);
                else if (r < 24)
                    stall_left = $urandom_range(10, 40);
            end
            if (stall_left > 0) begin
                stall_left--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    initial begin : stimulus
        int gap;
        s_valid = 1'b0;
        s_code_point = '0;
        aresetn = 1'b0;
        repeat (4) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        for (int i = 0; i < DIR_N; i++) send_item(dir_cp[i], dir_lit[i], pick_gap());
        for (int i = 0; i < RAND_N; i++) begin
            no_idle = (i >= 40 && i < 80);
            if (i == 120) hold_request = 1'b1;
            gap = (i >= 120 && i < 140) ? 0 : pick_gap();
            send_item(pick_code_point(), "", gap);
        end
        @(negedge aclk);
        s_valid <= 1'b0;
        while (expected_chars.size() != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);
        if (fail_count == 0 && expected_chars.size() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

    initial begin : watchdog
        #6000000;
        $display("== FAIL ==");
        $finish;
    end

endmodule
